// ----- design/stiru_pkg.sv -----
// Package for the slot table insert/remove unit.
// Holds default sizes, operation and status codes, stream field layout and the sequencer states.
// No dependencies.
package stiru_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_DEPTH      = 8;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed field widths of the request and result.
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 16;
    localparam int POS_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int CHANGED_W = 4;
    localparam int FIRST_W   = 3;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Operation codes carried on s_tuser.
    localparam logic [KIND_W-1:0] KIND_INS_FIRST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS_POS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FIRST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REM_COUNT = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BUSY      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_REM_SCAN,
        ST_RESP
    } state_t;

endpackage

// ----- design/stiru_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the slot value store; no dependencies.
module stiru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/slot_table_insert_remove_unit.sv -----
// Slot table insert/remove unit: top level with the sequencer, used marks and result register.
// Depends on stiru_pkg and on stiru_ram for the slot values.
//
// Usage:
// Requests arrive on the s_ stream: s_tuser carries the operation (insert at the lowest free
// slot, insert at a given slot, remove the first match, remove up to count matches) and
// s_tdata carries value, position and count. Every request gives exactly one result on the
// m_ stream: status, number of slots changed and the first slot changed.
// The block handles one request at a time; s_tready is high only while it is idle.
// A single compare unit walks the table one slot per cycle under a small sequencer.
// Insert at the lowest free slot walks the used marks from slot 0 up to the first free
// slot, refusing when the last slot is used too. Removal reads the value store through
// its registered port and ends early once count matches are freed. Insert at a position
// and removal with count zero finish in the acceptance cycle. The result is then held
// until m_tready is high, and the block returns to idle before the next acceptance.
// A stalled m_tready holds the result and keeps s_tready low.
// Reset (aresetn low, synchronous) marks every slot free and idles the sequencer.
module slot_table_insert_remove_unit
    import stiru_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value [15:0], position [18:16], count [22:19]
    input  logic [KIND_W-1:0]     s_tuser,   // kind [1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // status [1:0], changed [5:2], first_slot [8:6]
);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Request fields.
    logic [VALUE_W-1:0]    in_value;
    logic [POS_W-1:0]      in_pos;
    logic [COUNT_W-1:0]    in_count;
    logic [VALUE_BITS-1:0] in_val_w;
    logic [COUNT_W-1:0]    in_limit;
    logic                  in_accept;
    logic                  pos_ok;
    logic                  pos_free;

    // Sequencer and datapath registers.
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic                  issue_done_reg, issue_done_next;
    logic [DEPTH-1:0]      used_reg, used_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [COUNT_W-1:0]    limit_reg, limit_next;
    logic [CHANGED_W-1:0]  freed_reg, freed_next;
    logic [FIRST_W-1:0]    first_reg, first_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CHANGED_W-1:0]  changed_reg, changed_next;

    // Value store port.
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] rd_data;

    // Compare unit.
    logic                  hit;
    logic [CHANGED_W-1:0]  freed_inc;
    logic                  rem_stop;

    assign in_value  = s_tdata[15:0];
    assign in_pos    = s_tdata[18:16];
    assign in_count  = s_tdata[22:19];
    assign in_val_w  = VALUE_BITS'(in_value);
    assign in_limit  = (s_tuser == KIND_REM_FIRST) ? COUNT_W'(1) : in_count;
    assign in_accept = s_tvalid && s_tready;
    assign pos_ok    = int'(in_pos) < DEPTH;
    assign pos_free  = !used_reg[IDX_W'(in_pos)];

    // The shared compare: a used slot whose stored value matches the request value.
    assign hit       = cmp_vld_reg && used_reg[cmp_idx_reg] && (rd_data == val_reg);
    assign freed_inc = freed_reg + CHANGED_W'(1);
    assign rem_stop  = cmp_vld_reg && ((hit && freed_inc == limit_reg) || cmp_idx_reg == LAST_IDX);

    stiru_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_values (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (val_next),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (s_tuser)
                        KIND_INS_FIRST: state_next = ST_INS_SCAN;
                        KIND_INS_POS:   state_next = ST_RESP;
                        default:        state_next = (in_limit == '0) ? ST_RESP : ST_REM_SCAN;
                    endcase
                end
            end
            ST_INS_SCAN: begin
                if (!used_reg[scan_idx_reg] || scan_idx_reg == LAST_IDX) begin
                    state_next = ST_RESP;
                end
            end
            ST_REM_SCAN: begin
                if (rem_stop) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer.
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        issue_done_next = issue_done_reg;
        used_next       = used_reg;
        val_next        = val_reg;
        limit_next      = limit_reg;
        freed_next      = freed_reg;
        first_next      = first_reg;
        status_next     = status_reg;
        changed_next    = changed_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    val_next        = in_val_w;
                    limit_next      = in_limit;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    freed_next      = '0;
                    first_next      = '0;
                    status_next     = STAT_DONE;
                    changed_next    = '0;
                    if (s_tuser == KIND_INS_POS) begin
                        // Direct insert: only into a free slot inside the table.
                        if (pos_ok && pos_free) begin
                            wr_en                     = 1'b1;
                            wr_addr                   = IDX_W'(in_pos);
                            used_next[IDX_W'(in_pos)] = 1'b1;
                            changed_next              = CHANGED_W'(1);
                            first_next                = in_pos;
                        end else begin
                            status_next = STAT_BUSY;
                        end
                    end
                end
            end
            ST_INS_SCAN: begin
                // Walk the used marks until a free slot turns up or the last slot is reached.
                if (!used_reg[scan_idx_reg]) begin
                    wr_en                   = 1'b1;
                    used_next[scan_idx_reg] = 1'b1;
                    status_next             = STAT_DONE;
                    changed_next            = CHANGED_W'(1);
                    first_next              = FIRST_W'(scan_idx_reg);
                end else if (scan_idx_reg == LAST_IDX) begin
                    status_next = STAT_BUSY;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_REM_SCAN: begin
                // Issue one read per cycle; the compare runs in the cycle after each read is issued.
                cmp_vld_next = !issue_done_reg;
                cmp_idx_next = scan_idx_reg;
                if (!issue_done_reg) begin
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                if (hit) begin
                    used_next[cmp_idx_reg] = 1'b0;
                    freed_next             = freed_inc;
                    if (freed_reg == '0) begin
                        first_next = FIRST_W'(cmp_idx_reg);
                    end
                end
                if (rem_stop) begin
                    status_next  = (freed_next == '0) ? STAT_NOT_FOUND : STAT_DONE;
                    changed_next = freed_next;
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            cmp_vld_reg    <= cmp_vld_next;
            issue_done_reg <= issue_done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        val_reg      <= val_next;
        limit_reg    <= limit_next;
        freed_reg    <= freed_next;
        first_reg    <= first_next;
        status_reg   <= status_next;
        changed_reg  <= changed_next;
    end

    // Stream outputs.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESP);
    assign m_tdata  = {7'b0, first_reg, changed_reg, status_reg};

`ifndef ASSERT_OFF
    // No new request is taken while a result waits.
    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request accepted while a result is pending");

    // A miss changes no slot.
    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == STAT_NOT_FOUND) |-> (changed_reg == '0 && first_reg == '0))
        else $error("not-found result reports changed slots");

    // A refused insert changes no slot.
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == STAT_BUSY) |-> (changed_reg == '0 && first_reg == '0))
        else $error("refused insert reports changed slots");

    // The removal scan never runs past its limit.
    a_freed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM_SCAN) |-> (freed_reg < limit_reg))
        else $error("removal freed more slots than allowed");

    // A free slot found by the insert scan is marked used on the next cycle.
    a_insert_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_SCAN && !used_reg[scan_idx_reg]) |=> used_reg[$past(scan_idx_reg)])
        else $error("inserted slot not marked used");
`endif

endmodule
